// ===== hdl/aabb_pkg.sv =====
// ----------------------------------------------------------------------------
// aabb_pkg: shared types and constants
// Fixed-point widths and the per-slot record used by the box table.
// ----------------------------------------------------------------------------
package aabb_pkg;
	localparam int POS_W  = 24;
	localparam int HALF_W = 16;
	localparam int MOV_W  = 16;
	localparam int APP_W  = 25;
	localparam int EXT_W  = 27;
	localparam logic signed [EXT_W-1:0] POS_MAX = EXT_W'(8388607);
	localparam logic signed [EXT_W-1:0] POS_MIN = -EXT_W'(8388608);
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_MOVE  = 1'b1;

	typedef struct packed {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic [HALF_W-1:0]       hw;
		logic [HALF_W-1:0]       hh;
	} entry_t;

	function automatic logic signed [POS_W-1:0] sat24(input logic signed [EXT_W-1:0] v);
		if (v > POS_MAX)
			return POS_MAX[POS_W-1:0];
		else if (v < POS_MIN)
			return POS_MIN[POS_W-1:0];
		else
			return v[POS_W-1:0];
	endfunction
endpackage

// ===== hdl/aabb_cell.sv =====
// ----------------------------------------------------------------------------
// aabb_cell: one slot of the box table
// Holds an entry and its flags; passes its contents to the next cell each
// shift so the table circulates past the slide unit.
// ----------------------------------------------------------------------------
module aabb_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift,
	input  logic            load,
	input  aabb_pkg::entry_t load_e,
	input  logic [1:0]      load_f,
	input  aabb_pkg::entry_t prev_e,
	input  logic [1:0]      prev_f,
	output aabb_pkg::entry_t e,
	output logic [1:0]      f
);
	import aabb_pkg::*;

	entry_t e_q;
	logic [1:0] f_q;

	always_ff @(posedge clk) begin
		if (load)
			e_q <= load_e;
		else if (shift)
			e_q <= prev_e;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			f_q <= '0;
		else if (load)
			f_q <= load_f;
		else if (shift)
			f_q <= prev_f;
	end

	assign e = e_q;
	assign f = f_q;
endmodule

// ===== hdl/aabb_move_and_slide.sv =====
// ----------------------------------------------------------------------------
// aabb_move_and_slide: box table with move-and-slide
// A ring of cells holds the table; a move rotates the ring three times past a
// single slide unit: once to fetch the mover, then once per axis.
// ----------------------------------------------------------------------------
// channel | direction | handshake
// in      | to block  | in_valid / in_stall
// out     | from block| out_valid / out_stall
// A move on a present slot raises out_valid after three rotations of the ring:
// each rotation shifts the ring all the way round and then turns without a
// shift; one rotation fetches the mover, one is the x pass and one the y pass.
// The ring is rotated back to home on each full pass, so slot order is kept.
// Reset clears every present flag. in_stall is high while a move is in
// flight or its result waits on out_stall.
module aabb_move_and_slide #(
	parameter int MAX_OBJECTS = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic opcode,
	input  logic [5:0] object_index,
	input  logic signed [aabb_pkg::POS_W-1:0] pos_x,
	input  logic signed [aabb_pkg::POS_W-1:0] pos_y,
	input  logic [aabb_pkg::HALF_W-1:0] half_w,
	input  logic [aabb_pkg::HALF_W-1:0] half_h,
	input  logic present,
	input  logic has_box,
	input  logic signed [aabb_pkg::MOV_W-1:0] move_x,
	input  logic signed [aabb_pkg::MOV_W-1:0] move_y,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [aabb_pkg::POS_W-1:0] new_x,
	output logic signed [aabb_pkg::POS_W-1:0] new_y,
	output logic signed [aabb_pkg::APP_W-1:0] applied_x,
	output logic signed [aabb_pkg::APP_W-1:0] applied_y,
	output logic collided,
	output logic bad_index
);
	import aabb_pkg::*;

	localparam int IW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
	localparam int CW = $clog2(MAX_OBJECTS + 1);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_FIND = 2'd1;  // rotate to fetch the mover
	localparam logic [1:0] ST_PASS = 2'd2;  // slide passes
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0] state_q;
	logic [CW-1:0] cnt_q;      // cycles within the current rotation
	logic axis_q;              // 0 x pass, 1 y pass
	logic [IW-1:0] midx_q;
	entry_t mover_q;
	logic mbox_q, hit_q;
	logic signed [POS_W-1:0] sx_q, sy_q;
	logic signed [MOV_W-1:0] dx_q, dy_q;

	entry_t ce [MAX_OBJECTS];
	logic [1:0] cf [MAX_OBJECTS];
	logic shift;
	logic [MAX_OBJECTS-1:0] load_v;
	entry_t wr_e;
	logic [1:0] wr_f;
	logic in_range;
	logic [IW-1:0] widx;

	assign in_range = ({26'd0, object_index} < 32'(MAX_OBJECTS));
	assign widx = IW'(object_index);
	assign in_stall = (state_q != ST_IDLE);

	// cells: slot 0 sits at the head, fed from slot 1; the last slot is fed from slot 0
	genvar g;
	generate
		for (g = 0; g < MAX_OBJECTS; g++) begin : g_cell
			aabb_cell u_cell (
				.clk(clk), .arst_n(arst_n), .shift(shift), .load(load_v[g]),
				.load_e(wr_e), .load_f(wr_f),
				.prev_e(ce[(g + 1) % MAX_OBJECTS]), .prev_f(cf[(g + 1) % MAX_OBJECTS]),
				.e(ce[g]), .f(cf[g])
			);
		end
	endgenerate

	// head slot index = cnt (ring rotated cnt times)
	logic [IW-1:0] head_idx;
	assign head_idx = IW'(cnt_q);
	entry_t ob;
	assign ob = ce[0];
	logic ob_ok;
	assign ob_ok = (head_idx != midx_q) && (cf[0] == 2'b11) && mbox_q;

	// overlap test on 27-bit sums
	logic signed [EXT_W-1:0] px, py, mw, mh, ox, oy, ow, oh;
	logic ovl;
	always_comb begin
		px = EXT_W'(mover_q.x); py = EXT_W'(mover_q.y);
		mw = EXT_W'({1'b0, mover_q.hw}); mh = EXT_W'({1'b0, mover_q.hh});
		ox = EXT_W'(ob.x); oy = EXT_W'(ob.y);
		ow = EXT_W'({1'b0, ob.hw}); oh = EXT_W'({1'b0, ob.hh});
		ovl = (px - mw < ox + ow) && (px + mw > ox - ow) &&
		      (py - mh < oy + oh) && (py + mh > oy - oh);
	end

	logic signed [EXT_W-1:0] snap_c, snap_s, delta;
	logic signed [POS_W-1:0] snapped;
	always_comb begin
		snap_c = axis_q ? oy : ox;
		snap_s = axis_q ? (oh + mh) : (ow + mw);
		delta = axis_q ? EXT_W'(dy_q) : EXT_W'(dx_q);
		if (delta > 0)
			snapped = sat24(snap_c - snap_s);
		else if (delta < 0)
			snapped = sat24(snap_c + snap_s);
		else
			snapped = axis_q ? mover_q.y : mover_q.x;
	end

	// write path: table write from input, or mover write-back at the end
	logic wb;
	always_comb begin
		wb = (state_q == ST_PASS) && axis_q && (cnt_q == CW'(MAX_OBJECTS));
		shift = 1'b0;
		if ((state_q == ST_FIND || state_q == ST_PASS) && cnt_q != CW'(MAX_OBJECTS))
			shift = 1'b1;
		if (wb) begin
			wr_e = mover_q;
			wr_f = 2'b01 | {mbox_q, 1'b0};
		end else begin
			wr_e.x = pos_x; wr_e.y = pos_y; wr_e.hw = half_w; wr_e.hh = half_h;
			wr_f = {has_box, present};
		end
		load_v = '0;
		if (wb)
			load_v[midx_q] = 1'b1;
		else if (state_q == ST_IDLE && in_valid && opcode == OP_WRITE && in_range)
			load_v[widx] = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			midx_q <= widx;
			dx_q <= move_x;
			dy_q <= move_y;
			hit_q <= 1'b0;
		end
		if (state_q == ST_FIND && head_idx == midx_q && cnt_q != CW'(MAX_OBJECTS)) begin
			mover_q.hw <= ob.hw;
			mover_q.hh <= ob.hh;
			mover_q.y <= ob.y;
			mover_q.x <= sat24(EXT_W'(ob.x) + EXT_W'(dx_q));
			sx_q <= ob.x;
			sy_q <= ob.y;
			mbox_q <= cf[0][1];
		end
		if (state_q == ST_PASS && cnt_q != CW'(MAX_OBJECTS) && ob_ok && ovl) begin
			hit_q <= 1'b1;
			if (axis_q) mover_q.y <= snapped;
			else mover_q.x <= snapped;
		end
		if (state_q == ST_PASS && !axis_q && cnt_q == CW'(MAX_OBJECTS))
			mover_q.y <= sat24(EXT_W'(mover_q.y) + EXT_W'(dy_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			axis_q <= 1'b0;
			out_valid <= 1'b0;
			new_x <= '0;
			new_y <= '0;
			applied_x <= '0;
			applied_y <= '0;
			collided <= 1'b0;
			bad_index <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					axis_q <= 1'b0;
					if (in_valid && opcode == OP_MOVE) begin
						if (in_range && cf[widx][0]) begin
							state_q <= ST_FIND;
						end else begin
							new_x <= '0; new_y <= '0; applied_x <= '0; applied_y <= '0;
							collided <= 1'b0; bad_index <= 1'b1;
							out_valid <= 1'b1;
							state_q <= ST_OUT;
						end
					end
				end
				ST_FIND, ST_PASS: begin
					if (cnt_q == CW'(MAX_OBJECTS)) begin
						cnt_q <= '0;
						if (state_q == ST_FIND) begin
							state_q <= ST_PASS;
						end else if (!axis_q) begin
							axis_q <= 1'b1;
						end else begin
							new_x <= mover_q.x;
							new_y <= mover_q.y;
							applied_x <= APP_W'(mover_q.x) - APP_W'(sx_q);
							applied_y <= APP_W'(mover_q.y) - APP_W'(sy_q);
							collided <= hit_q;
							bad_index <= 1'b0;
							out_valid <= 1'b1;
							state_q <= ST_OUT;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== verif/aabb_move_and_slide_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aabb_move_and_slide_tb: self-checking bench for the box table
// Drives write and move requests through the valid/stall handshake. A local
// model of the table predicts each move result, and a checker compares every
// result field by field. The receiver side is stalled at random and once for
// a long stretch, so the block backs up and stalls its input.
// ----------------------------------------------------------------------------
module aabb_move_and_slide_tb;
	import aabb_pkg::*;

	localparam int SLOTS       = 64;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic signed [POS_W-1:0] nx;
		logic signed [POS_W-1:0] ny;
		logic signed [APP_W-1:0] ax;
		logic signed [APP_W-1:0] ay;
		logic                    hit;
		logic                    bad;
	} move_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic opcode = OP_WRITE;
	logic [5:0] object_index = '0;
	logic signed [POS_W-1:0] pos_x = '0;
	logic signed [POS_W-1:0] pos_y = '0;
	logic [HALF_W-1:0] half_w = '0;
	logic [HALF_W-1:0] half_h = '0;
	logic present = 1'b0;
	logic has_box = 1'b0;
	logic signed [MOV_W-1:0] move_x = '0;
	logic signed [MOV_W-1:0] move_y = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [POS_W-1:0] new_x;
	logic signed [POS_W-1:0] new_y;
	logic signed [APP_W-1:0] applied_x;
	logic signed [APP_W-1:0] applied_y;
	logic collided;
	logic bad_index;

	// local copy of the box table
	logic signed [POS_W-1:0] tbl_x [SLOTS];
	logic signed [POS_W-1:0] tbl_y [SLOTS];
	logic [HALF_W-1:0]       tbl_w [SLOTS];
	logic [HALF_W-1:0]       tbl_h [SLOTS];
	logic                    tbl_present [SLOTS];
	logic                    tbl_box [SLOTS];

	move_res_t pending_moves[$];
	int  mismatches = 0;
	int  cycles = 0;
	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	int  hold_cycles = 0;   // long receiver hold-off, counted down below

	aabb_move_and_slide #(.MAX_OBJECTS(SLOTS)) u_dut (.*);

	always #2 clk = ~clk;

	// timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// receiver: random stalls plus an optional long hold-off
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else
			out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	task automatic report(input string what, input longint got, input longint want);
		mismatches++;
		$display("mismatch %s: got %0d expected %0d", what, got, want);
	endtask

	// result checker
	always @(posedge clk) begin
		move_res_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_moves.size() == 0) begin
				report("unexpected result", 1, 0);
			end else begin
				e = pending_moves.pop_front();
				if (new_x !== e.nx) report("new_x", new_x, e.nx);
				if (new_y !== e.ny) report("new_y", new_y, e.ny);
				if (applied_x !== e.ax) report("applied_x", applied_x, e.ax);
				if (applied_y !== e.ay) report("applied_y", applied_y, e.ay);
				if (collided !== e.hit) report("collided", collided, e.hit);
				if (bad_index !== e.bad) report("bad_index", bad_index, e.bad);
			end
		end
	end

	function automatic logic signed [POS_W-1:0] clamp_pos(input longint v);
		if (v > 8388607) return 24'sd8388607;
		if (v < -8388608) return -24'sd8388608;
		return v[POS_W-1:0];
	endfunction

	// one axis pass of the slide; updates px/py, returns whether anything overlapped
	function automatic logic slide_pass(input int m, inout longint px, inout longint py,
			input longint delta, input bit axis_y);
		logic   touched = 1'b0;
		longint mw, mh, ox, oy, ow, oh, span, c;
		if (!tbl_box[m]) return 1'b0;
		mw = longint'(tbl_w[m]);
		mh = longint'(tbl_h[m]);
		for (int j = 0; j < SLOTS; j++) begin
			if (j == m || !tbl_present[j] || !tbl_box[j]) continue;
			ox = longint'(tbl_x[j]); oy = longint'(tbl_y[j]);
			ow = longint'(tbl_w[j]); oh = longint'(tbl_h[j]);
			if (!((px - mw < ox + ow) && (px + mw > ox - ow) &&
			      (py - mh < oy + oh) && (py + mh > oy - oh))) continue;
			c    = axis_y ? oy : ox;
			span = axis_y ? oh + mh : ow + mw;
			if (delta > 0) c = c - span;
			else if (delta < 0) c = c + span;
			if (delta != 0) begin
				if (axis_y) py = clamp_pos(c);
				else px = clamp_pos(c);
			end
			touched = 1'b1;
		end
		return touched;
	endfunction

	function automatic move_res_t predict_move(input int m, input longint dx, input longint dy);
		move_res_t r = '0;
		longint px, py, sx, sy;
		logic h;
		if (!tbl_present[m]) begin
			r.bad = 1'b1;
			return r;
		end
		sx = longint'(tbl_x[m]); sy = longint'(tbl_y[m]);
		px = clamp_pos(sx + dx);
		py = sy;
		h = slide_pass(m, px, py, dx, 1'b0);
		py = clamp_pos(py + dy);
		if (slide_pass(m, px, py, dy, 1'b1)) h = 1'b1;
		tbl_x[m] = POS_W'(px);
		tbl_y[m] = POS_W'(py);
		r.nx = POS_W'(px); r.ny = POS_W'(py);
		r.ax = APP_W'(px - sx); r.ay = APP_W'(py - sy);
		r.hit = h;
		return r;
	endfunction

	// drive one request and wait for it to be taken; update prediction on accept
	task automatic send_request(input logic op, input logic [5:0] idx,
			input logic signed [POS_W-1:0] x, input logic signed [POS_W-1:0] y,
			input logic [HALF_W-1:0] w, input logic [HALF_W-1:0] h,
			input logic pr, input logic bx,
			input logic signed [MOV_W-1:0] mx, input logic signed [MOV_W-1:0] my);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		opcode <= op; object_index <= idx; pos_x <= x; pos_y <= y;
		half_w <= w; half_h <= h; present <= pr; has_box <= bx;
		move_x <= mx; move_y <= my;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		if (op == OP_WRITE) begin
			tbl_x[idx] = x; tbl_y[idx] = y; tbl_w[idx] = w; tbl_h[idx] = h;
			tbl_present[idx] = pr; tbl_box[idx] = bx;
		end else
			pending_moves.push_back(predict_move(int'(idx), longint'(mx), longint'(my)));
		@(negedge clk);
	endtask

	task automatic write_entry(input int idx, input int x, input int y,
			input int w, input int h, input logic pr, input logic bx);
		send_request(OP_WRITE, 6'(idx), POS_W'(x), POS_W'(y), HALF_W'(w), HALF_W'(h),
			pr, bx, MOV_W'($urandom), MOV_W'($urandom));
	endtask

	task automatic move_entry(input int idx, input int mx, input int my);
		send_request(OP_MOVE, 6'(idx), POS_W'($urandom), POS_W'($urandom),
			HALF_W'($urandom), HALF_W'($urandom), 1'($urandom), 1'($urandom),
			MOV_W'(mx), MOV_W'(my));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_moves.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// empty slots, free movement, an x slide, zero delta, saturation
	task automatic test_directed();
		move_entry(5, 100, 100);                         // empty mover
		write_entry(1, 0, 0, 256, 256, 1, 1);
		write_entry(2, 2048, 0, 256, 256, 1, 1);
		write_entry(3, 0, 0, 65535, 65535, 1, 0);        // no box: free mover
		move_entry(3, 32767, -32768);
		move_entry(1, 2000, 0);                          // slide into slot 2 from the left
		move_entry(1, -32768, 0);                        // back away
		write_entry(4, 0, 4096, 256, 256, 1, 1);
		move_entry(4, 0, -4000);                         // y move; slot 1 has backed away, so no slide
		move_entry(4, 0, 0);                             // zero delta
		write_entry(6, 0, 4096, 512, 512, 0, 1);         // absent slot: its move reports bad_index
		move_entry(6, 1, 1);
		write_entry(7, 8388607, -8388608, 0, 0, 1, 1);   // extremes, saturate
		move_entry(7, 32767, -32768);
		move_entry(7, -32768, 32767);
		write_entry(8, 8388600, 0, 65535, 65535, 1, 1);
		write_entry(9, -8388608, 8388607, 65535, 0, 1, 1);
		move_entry(8, 32767, 0);
		move_entry(9, -32768, 32767);
		write_entry(1, 0, 0, 0, 0, 0, 0);                // clear slot 1
		move_entry(1, 1, 1);
		move_entry(63, -1, -1);
		drain();
	endtask

	// mostly clustered boxes so moves often collide
	task automatic random_items(input int count);
		int idx;
		for (int i = 0; i < count; i++) begin
			idx = $urandom_range(15) == 0 ? $urandom_range(63) : $urandom_range(11);
			if ($urandom_range(99) < 35) begin
				if ($urandom_range(19) == 0)
					write_entry(idx, int'($signed(24'($urandom))), int'($signed(24'($urandom))),
						$urandom, $urandom, 1'($urandom), 1'($urandom));
				else
					write_entry(idx, $signed($urandom_range(8192)) - 4096,
						$signed($urandom_range(8192)) - 4096, $urandom_range(1024),
						$urandom_range(1024), $urandom_range(7) != 0,
						$urandom_range(5) != 0);
			end else if ($urandom_range(9) == 0)
				move_entry(idx, int'($signed(16'($urandom))), int'($signed(16'($urandom))));
			else
				move_entry(idx, $signed($urandom_range(2048)) - 1024,
					$urandom_range(3) == 0 ? 0 : $signed($urandom_range(2048)) - 1024);
		end
	endtask

	task automatic test_slow_sender();
		send_idle_pct = 36; recv_idle_pct = 58;
		random_items(500);
		drain();
	endtask

	task automatic test_slow_receiver();
		send_idle_pct = 58; recv_idle_pct = 36;
		random_items(500);
		drain();
	endtask

	task automatic test_back_pressure();
		send_idle_pct = 0; recv_idle_pct = 0;
		@(negedge clk);
		hold_cycles = 3000;   // long hold-off while requests keep coming
		random_items(700);
		drain();
	endtask

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			tbl_present[i] = 1'b0; tbl_box[i] = 1'b0;
			tbl_x[i] = '0; tbl_y[i] = '0; tbl_w[i] = '0; tbl_h[i] = '0;
		end
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_slow_sender();
		test_slow_receiver();
		test_back_pressure();
		repeat (200) @(negedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
